// File: sv/tracking_wheel_odometry_assert.svh
// ----------------------------------------------------------------------------
// Tracking wheel odometry assertion macros
// Shared property forms for the odometry block checks.
// ----------------------------------------------------------------------------
`ifndef TRACKING_WHEEL_ODOMETRY_ASSERT_SVH
`define TRACKING_WHEEL_ODOMETRY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TWO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("odometry check failed");

// Next-cycle implication, disabled during reset.
`define TWO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("odometry check failed");

`endif

// File: sv/twodo_pkg.sv
// ----------------------------------------------------------------------------
// Tracking wheel odometry package
// Constants, command codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package twodo_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [31:0] INCH_PER_CENTIDEG_RESET = 32'd749511;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_RESET  = 1'b1;

  localparam int HALF_TURN  = 18000;
  localparam int FULL_TURN  = 36000;
  localparam int QUARTER    = 9000;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/tracking_wheel_odometry.sv
// ----------------------------------------------------------------------------
// Tracking wheel odometry
// Channel  Dir  Handshake             Payload
// s_axis   in   tvalid/tready         tuser cmd; tdata wheel angles, heading, start pose
// m_axis   out  tvalid/tready         tdata pose and normalized heading
// cfg      in   cfg_we                cfg_data inch per centidegree factor
// An update request passes heading wrap, a 32-step serial divide and wheel
// multiply, 16 CORDIC steps and an 18-step serial rotate. A reset request
// passes only the heading wrap. One request is in work at a time.
// The result register lets a new request enter while the last pose waits.
// Reset is synchronous, clears the pose and the last angles, and restores the
// factor to its reset value.
// ----------------------------------------------------------------------------
module tracking_wheel_odometry (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic         s_axis_tuser,   // cmd
  // forward_angle, lateral_angle, heading_in, start_x, start_y, zero pad
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,   // pos_x, pos_y, heading_out
  input  logic         cfg_we,
  input  logic [31:0]  cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NORM  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_ZSET  = 4'd3;
  localparam logic [3:0] S_ROT   = 4'd4;
  localparam logic [3:0] S_ROUND = 4'd5;
  localparam logic [3:0] S_PROD  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state;
  logic [31:0] inch_per_centideg;
  logic signed [31:0] last_forward, last_lateral, acc_x, acc_y;
  logic signed [15:0] cur_heading;
  logic cmd;
  logic signed [17:0] hd;
  logic flip, neg_z;
  logic [16:0] rem;
  logic [31:0] quo;
  logic [32:0] mag_f, mag_l;
  logic sgn_f, sgn_l;
  logic [64:0] prod_f, prod_l;
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic signed [17:0] cos_v, sin_v;
  logic signed [46:0] mf, ml;
  logic signed [63:0] acc_p, acc_q;
  logic [5:0] cnt;

  logic s_fire;
  logic signed [31:0] in_fwd, in_lat, in_sx, in_sy;
  logic signed [16:0] in_head;
  logic signed [32:0] d_f, d_l;
  logic signed [17:0] hf;
  logic [16:0] hf_abs;
  logic [17:0] r2;
  logic signed [33:0] dxs, dys;
  logic signed [32:0] at;
  logic signed [33:0] xr, yr;
  logic signed [17:0] cos_n, sin_n;
  logic [48:0] m_f, m_l;
  logic [45:0] mc_f, mc_l;
  logic [4:0] j;
  logic signed [63:0] tf, tl, term_p, term_q;
  logic signed [48:0] sum_x, sum_y;
  logic signed [15:0] out_head;

  assign s_axis_tready = (state == S_IDLE);
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign in_fwd  = s_axis_tdata[31:0];
  assign in_lat  = s_axis_tdata[63:32];
  assign in_head = s_axis_tdata[80:64];
  assign in_sx   = s_axis_tdata[112:81];
  assign in_sy   = s_axis_tdata[144:113];
  assign out_head = m_axis_tdata[79:64];

  assign d_f = {in_fwd[31], in_fwd} - {last_forward[31], last_forward};
  assign d_l = {in_lat[31], in_lat} - {last_lateral[31], last_lateral};

  always_comb begin
    if (hd > 18'sd9000) begin
      hf = hd - 18'sd18000;
    end else if (hd < -18'sd9000) begin
      hf = hd + 18'sd18000;
    end else begin
      hf = hd;
    end
    hf_abs = hf[17] ? 17'(-hf) : hf[16:0];
  end

  assign r2 = {rem, 1'b0};
  assign dxs = cy >>> cnt[4:0];
  assign dys = cx >>> cnt[4:0];
  assign at = $signed({1'b0, twodo_pkg::atan_val(cnt[4:0])});

  always_comb begin
    xr = (cx + 34'sd8192) >>> 14;
    yr = (cy + 34'sd8192) >>> 14;
    if (xr > 34'sd65536) begin
      cos_n = 18'sd65536;
    end else if (xr < -34'sd65536) begin
      cos_n = -18'sd65536;
    end else begin
      cos_n = xr[17:0];
    end
    if (yr > 34'sd65536) begin
      sin_n = 18'sd65536;
    end else if (yr < -34'sd65536) begin
      sin_n = -18'sd65536;
    end else begin
      sin_n = yr[17:0];
    end
    m_f = prod_f[64:16];
    m_l = prod_l[64:16];
    mc_f = (m_f > 49'h2000_0000_0000) ? 46'h2000_0000_0000 : m_f[45:0];
    mc_l = (m_l > 49'h2000_0000_0000) ? 46'h2000_0000_0000 : m_l[45:0];
  end

  always_comb begin
    j = cnt[4:0];
    tf = 64'(mf);
    tl = 64'(ml);
    term_p = (cos_v[j] ? tf : 64'sd0) - (sin_v[j] ? tl : 64'sd0);
    term_q = (sin_v[j] ? tf : 64'sd0) + (cos_v[j] ? tl : 64'sd0);
    if (j == 5'd17) begin
      term_p = -term_p;
      term_q = -term_q;
    end
    sum_x = 49'(acc_x) + 49'($signed(acc_p[63:16]));
    sum_y = 49'(acc_y) + 49'($signed(acc_q[63:16]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      inch_per_centideg <= twodo_pkg::INCH_PER_CENTIDEG_RESET;
      last_forward <= '0;
      last_lateral <= '0;
      acc_x <= '0;
      acc_y <= '0;
      cur_heading <= '0;
      m_axis_tvalid <= 1'b0;
      cnt <= '0;
    end else begin
      if (cfg_we) begin
        inch_per_centideg <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            cmd <= s_axis_tuser;
            hd <= 18'(in_head);
            if (s_axis_tuser == twodo_pkg::CMD_RESET) begin
              acc_x <= in_sx;
              acc_y <= in_sy;
              last_forward <= '0;
              last_lateral <= '0;
            end else begin
              last_forward <= in_fwd;
              last_lateral <= in_lat;
              sgn_f <= d_f[32];
              sgn_l <= d_l[32];
              mag_f <= d_f[32] ? 33'(-d_f) : d_f;
              mag_l <= d_l[32] ? 33'(-d_l) : d_l;
            end
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (hd >= 18'sd18000) begin
            hd <= hd - 18'sd36000;
          end else if (hd < -18'sd18000) begin
            hd <= hd + 18'sd36000;
          end else begin
            cur_heading <= hd[15:0];
            flip <= (hd != hf);
            neg_z <= hf[17];
            rem <= hf_abs;
            quo <= '0;
            prod_f <= '0;
            prod_l <= '0;
            cnt <= '0;
            state <= (cmd == twodo_pkg::CMD_RESET) ? S_OUT : S_DIV;
          end
        end
        S_DIV: begin
          if (r2 >= 18'd36000) begin
            rem <= 17'(r2 - 18'd36000);
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= r2[16:0];
            quo <= {quo[30:0], 1'b0};
          end
          prod_f <= {prod_f[63:0], 1'b0}
                    + (inch_per_centideg[~cnt[4:0]] ? 65'(mag_f) : 65'd0);
          prod_l <= {prod_l[63:0], 1'b0}
                    + (inch_per_centideg[~cnt[4:0]] ? 65'(mag_l) : 65'd0);
          if (cnt == 6'd31) begin
            state <= S_ZSET;
          end
          cnt <= cnt + 6'd1;
        end
        S_ZSET: begin
          cz <= neg_z ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
          cx <= $signed(twodo_pkg::CORDIC_GAIN);
          cy <= '0;
          cnt <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (!cz[32]) begin
            cx <= cx - dxs;
            cy <= cy + dys;
            cz <= cz - at;
          end else begin
            cx <= cx + dxs;
            cy <= cy - dys;
            cz <= cz + at;
          end
          if (cnt == 6'(twodo_pkg::CORDIC_ITERATIONS - 1)) begin
            state <= S_ROUND;
          end
          cnt <= cnt + 6'd1;
        end
        S_ROUND: begin
          cos_v <= flip ? -cos_n : cos_n;
          sin_v <= flip ? -sin_n : sin_n;
          mf <= sgn_f ? -$signed({1'b0, mc_f}) : $signed({1'b0, mc_f});
          ml <= sgn_l ? -$signed({1'b0, mc_l}) : $signed({1'b0, mc_l});
          acc_p <= '0;
          acc_q <= '0;
          cnt <= 6'd17;
          state <= S_PROD;
        end
        S_PROD: begin
          acc_p <= (acc_p <<< 1) + term_p;
          acc_q <= (acc_q <<< 1) + term_q;
          if (cnt == 6'd0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_FIN: begin
          if (sum_x > 49'sh0_7FFF_FFFF) begin
            acc_x <= 32'sh7FFF_FFFF;
          end else if (sum_x < -49'sh0_8000_0000) begin
            acc_x <= 32'sh8000_0000;
          end else begin
            acc_x <= sum_x[31:0];
          end
          if (sum_y > 49'sh0_7FFF_FFFF) begin
            acc_y <= 32'sh7FFF_FFFF;
          end else if (sum_y < -49'sh0_8000_0000) begin
            acc_y <= 32'sh8000_0000;
          end else begin
            acc_y <= sum_y[31:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= {cur_heading, acc_y, acc_x};
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "tracking_wheel_odometry_assert.svh"

  `TWO_ASSERT_NEXT(a_accept_busy, s_fire, state == S_NORM)
  `TWO_ASSERT_NOW(a_head_range, m_axis_tvalid, (out_head >= -16'sd18000) && (out_head < 16'sd18000))
  `TWO_ASSERT_NEXT(a_fin_out, state == S_FIN, state == S_OUT)
  `TWO_ASSERT_NOW(a_rot_count, state == S_ROT, cnt < 6'(twodo_pkg::CORDIC_ITERATIONS))

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Tracking wheel odometry testbench
// Streams update and reset-pose requests into the odometry block, predicts
// each pose with an independent fixed-point model of the wheel scaling,
// heading wrap, CORDIC rotation and saturating accumulation, and checks
// every result in order under varied factor settings and flow control.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] fwd;
    logic signed [31:0] lat;
    logic signed [16:0] hdg;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } odo_req_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] ph;
  } pose_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic         s_axis_tuser = 1'b0;
  logic [151:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_data = '0;

  odo_req_t req_q[$];
  pose_t    pose_q[$];
  int       errors = 0;
  int       send_idle = 0;
  int       recv_stall = 0;

  logic [31:0]        m_factor;
  logic signed [31:0] m_last_f, m_last_l, m_x, m_y;
  logic signed [15:0] m_hdg;

  tracking_wheel_odometry dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] wrap_heading(longint h);
    longint r;
    r = (h + twodo_pkg::HALF_TURN) % twodo_pkg::FULL_TURN;
    if (r < 0) r += twodo_pkg::FULL_TURN;
    return 16'(r - twodo_pkg::HALF_TURN);
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  task automatic heading_sincos(input longint h, output longint c, output longint s);
    bit     flip;
    longint x, y, z, dx, dy;
    longint atan_k[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                           21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                           333772, 166886, 83443, 41722, 20861};
    flip = 0;
    x = 652032874;
    y = 0;
    if (h > twodo_pkg::QUARTER) begin h -= twodo_pkg::HALF_TURN; flip = 1; end
    else if (h < -twodo_pkg::QUARTER) begin h += twodo_pkg::HALF_TURN; flip = 1; end
    z = (h * 64'sd4294967296) / twodo_pkg::FULL_TURN;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin x -= dx; y += dy; z -= atan_k[i]; end
      else begin x += dx; y -= dy; z += atan_k[i]; end
    end
    x = unit_clamp(floor_shr(x + 8192, 14));
    y = unit_clamp(floor_shr(y + 8192, 14));
    if (flip) begin x = -x; y = -y; end
    c = x;
    s = y;
  endtask

  function automatic longint wheel_move(longint d, logic [31:0] k);
    longint unsigned mag, m;
    mag = d < 0 ? longint'(-d) : longint'(d);
    m = mag * (k >> 16) + ((mag * (k & 32'hFFFF)) >> 16);
    if (m > (64'd1 << 45)) m = 64'd1 << 45;
    return d < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [31:0] sat_pos(longint v);
    if (v > 2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  task automatic predict_pose(input odo_req_t r);
    longint mf, ml, c, s;
    pose_t  p;
    m_hdg = wrap_heading(longint'(r.hdg));
    if (r.cmd == twodo_pkg::CMD_RESET) begin
      m_x = r.sx;
      m_y = r.sy;
      m_last_f = 0;
      m_last_l = 0;
    end else begin
      mf = wheel_move(longint'(r.fwd) - longint'(m_last_f), m_factor);
      ml = wheel_move(longint'(r.lat) - longint'(m_last_l), m_factor);
      m_last_f = r.fwd;
      m_last_l = r.lat;
      heading_sincos(longint'(m_hdg), c, s);
      m_x = sat_pos(longint'(m_x) + floor_shr(mf * c - ml * s, 16));
      m_y = sat_pos(longint'(m_y) + floor_shr(mf * s + ml * c, 16));
    end
    p.px = m_x;
    p.py = m_y;
    p.ph = m_hdg;
    pose_q.push_back(p);
  endtask

  // Driver: predicts at acceptance so the model follows the block's order.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pose(req_q.pop_front());
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (req_q.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
            !($urandom_range(99) < send_idle)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= req_q[0].cmd;
          s_axis_tdata <= {8'd0, req_q[0].sy, req_q[0].sx, req_q[0].hdg,
                           req_q[0].lat, req_q[0].fwd};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    pose_t exp_p;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pose_q.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          errors++;
        end else begin
          exp_p = pose_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_p.px) begin
            $error("pos_x expected %0d actual %0d", exp_p.px, $signed(m_axis_tdata[31:0]));
            errors++;
          end
          if (m_axis_tdata[63:32] !== exp_p.py) begin
            $error("pos_y expected %0d actual %0d", exp_p.py, $signed(m_axis_tdata[63:32]));
            errors++;
          end
          if (m_axis_tdata[79:64] !== exp_p.ph) begin
            $error("heading_out expected %0d actual %0d", exp_p.ph,
                   $signed(m_axis_tdata[79:64]));
            errors++;
          end
        end
      end
      m_axis_tready <= !($urandom_range(99) < recv_stall);
    end
  end

  function automatic logic signed [31:0] edge_word();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 0;
      3: return $urandom_range(2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic odo_req_t rand_req();
    odo_req_t r;
    r.cmd = ($urandom_range(15) == 0) ? twodo_pkg::CMD_RESET : twodo_pkg::CMD_UPDATE;
    r.fwd = edge_word();
    r.lat = edge_word();
    r.hdg = 17'($urandom_range(72000)) - 17'sd36000;
    r.sx = edge_word();
    r.sy = edge_word();
    return r;
  endfunction

  task automatic add_req(logic c, int f, int l, int h, int x, int y);
    odo_req_t r;
    r.cmd = c; r.fwd = f; r.lat = l; r.hdg = 17'(h); r.sx = x; r.sy = y;
    req_q.push_back(r);
  endtask

  task automatic drain();
    while (req_q.size() != 0 || s_axis_tvalid || pose_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_factor(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_factor = v;
  endtask

  initial begin
    logic [31:0] factors[6] = '{32'd749511, 32'hFFFFFFFF, 32'd0, 32'd1,
                                32'h00010000, 32'h12345678};
    m_factor = twodo_pkg::INCH_PER_CENTIDEG_RESET;
    m_last_f = 0; m_last_l = 0; m_x = 0; m_y = 0; m_hdg = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Directed: heading extremes and folds, wheel extremes, huge moves, saturation.
    add_req(twodo_pkg::CMD_UPDATE, 3600, 0, 0, 0, 0);
    add_req(twodo_pkg::CMD_UPDATE, 3600, 3600, 9000, 0, 0);
    add_req(twodo_pkg::CMD_UPDATE, 7200, 0, 9001, 0, 0);
    add_req(twodo_pkg::CMD_UPDATE, 7200, -100, -9001, 0, 0);
    add_req(twodo_pkg::CMD_UPDATE, 0, 0, 36000, 0, 0);
    add_req(twodo_pkg::CMD_UPDATE, 0, 0, -36000, 0, 0);
    add_req(twodo_pkg::CMD_UPDATE, 0, 0, 18000, 0, 0);
    add_req(twodo_pkg::CMD_UPDATE, 0, 0, -18000, 0, 0);
    add_req(twodo_pkg::CMD_RESET, 5, 5, 27000, 32'h7FFF0000, 32'h80010000);
    add_req(twodo_pkg::CMD_UPDATE, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0);
    add_req(twodo_pkg::CMD_UPDATE, 32'h80000000, 32'h7FFFFFFF, 4500, 0, 0);
    add_req(twodo_pkg::CMD_UPDATE, 32'h7FFFFFFF, 32'h7FFFFFFF, -13500, 0, 0);
    add_req(twodo_pkg::CMD_RESET, 0, 0, -36000, 32'h80000000, 32'h7FFFFFFF);
    add_req(twodo_pkg::CMD_UPDATE, -500, 500, 17999, 0, 0);
    drain();
    write_factor(32'hFFFFFFFF);
    add_req(twodo_pkg::CMD_UPDATE, 32'h7FFFFFFF, 32'h80000000, 1234, 0, 0);
    add_req(twodo_pkg::CMD_UPDATE, 32'h80000000, 32'h7FFFFFFF, -31000, 0, 0);
    add_req(twodo_pkg::CMD_UPDATE, 1, -1, 0, 0, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_factor(factors[ph]);
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 74; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 74; end
        default: begin send_idle = 32; recv_stall = 32; end
      endcase
      for (int i = 0; i < 275; i++) req_q.push_back(rand_req());
      drain();
    end
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end
endmodule
